FILE: sv/v3au_pkg.sv
// Shared opcodes, widths and saturation helper for the 3D vector arithmetic unit.
package v3au_pkg;

  // Default number of fraction bits in the fixed-point words.
  localparam int FRAC_BITS_DEF = 16;

  // Bits in one fixed-point word.
  localparam int WORD_W = 32;

  // One root bit per stage for the square root of a 64-bit sum.
  localparam int SQ_STAGES = 32;

  // Saturation bounds on the wide intermediate values.
  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  // Operation codes carried on the input side-band.
  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_SCALE = 3'd2,
    OP_DIV   = 3'd3,
    OP_DOT   = 3'd4,
    OP_CROSS = 3'd5,
    OP_MAG   = 3'd6,
    OP_NORM  = 3'd7
  } op_t;

  // Clamp a wide signed value to one word; the top bit reports clamping.
  function automatic logic [WORD_W:0] sat66(input logic signed [65:0] v);
    logic [WORD_W:0] res;
    if (v > SAT_MAX) begin
      res = {1'b1, 32'h7fff_ffff};
    end else if (v < SAT_MIN) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[WORD_W-1:0]};
    end
    return res;
  endfunction

endpackage

FILE: sv/vector3_arithmetic_unit.sv
// Top level of the 3D vector arithmetic unit: lanes, root, dividers and result merge.
//
// Fixed-point 3D vector unit (add, subtract, scale, divide, dot, cross, magnitude,
// normalize) on signed 32-bit words with FRAC_BITS fraction bits. It takes one
// request per clock while the skid buffer is empty, and every operation flows
// through the same pipeline: the lanes, the 32-stage square root and then the
// (32 + FRAC_BITS)-stage dividers that serve normalize and divide. A result waiting
// on the output does not stop intake at once: a one-entry skid buffer takes the
// next finished result, and only then is the input held off.
module vector3_arithmetic_unit import v3au_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, scalar_in (32 bits each), from bit 0 up
  input  logic [223:0] s_axis_tdata,
  // op
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // r_x, r_y, r_z, scalar_out (32 bits each), divide_by_zero, overflow, 6 zero bits
  output logic [135:0] m_axis_tdata
);

  localparam int QW = WORD_W + FRAC_BITS;

  typedef struct packed {
    op_t                    op;
    logic [2:0][WORD_W-1:0] a;
    logic [WORD_W-1:0]      s;
    logic [2:0][WORD_W-1:0] r;
    logic [2:0]             rovf;
    logic [WORD_W-1:0]      dot;
    logic                   dot_ovf;
    logic [WORD_W-1:0]      root;
    logic [2:0]             neg;
    logic                   dz;
  } pay_t;

  typedef struct packed {
    logic                   ovf;
    logic                   dz;
    logic [WORD_W-1:0]      sc;
    logic [2:0][WORD_W-1:0] r;
  } res_t;

  logic                   en;
  op_t                    op_in;
  logic [2:0][WORD_W-1:0] a_in;
  logic [2:0][WORD_W-1:0] b_in;
  logic [WORD_W-1:0]      s_in;

  logic                   v1;
  op_t                    op1;
  logic [2:0][WORD_W-1:0] a1;
  logic [WORD_W-1:0]      s1;

  logic                   v2;
  op_t                    op2;
  logic [2:0][WORD_W-1:0] a2;
  logic [WORD_W-1:0]      s2;
  logic [WORD_W-1:0]      dot2;
  logic                   dot_ovf2;
  logic [63:0]            sq2;

  logic signed [63:0]     lane_prod [3];
  logic [WORD_W-1:0]      lane_r    [3];
  logic                   lane_rovf [3];

  logic signed [65:0]     dsum;
  logic [WORD_W:0]        dsat;
  logic [63:0]            sqsum;
  pay_t                   p2;

  pay_t                   pl [SQ_STAGES];
  logic                   pv [SQ_STAGES];
  logic [WORD_W-1:0]      root;

  pay_t                   pe;
  logic [2:0][WORD_W-1:0] dnum;
  logic [WORD_W-1:0]      dden;
  logic [WORD_W-1:0]      abs_s;

  pay_t                   dl [QW];
  logic                   dv [QW];
  logic [QW-1:0]          quo [3];

  res_t                   res;
  res_t                   od;
  res_t                   skid_d;
  logic                   skid_v;

  // Unpack the request.
  assign op_in = op_t'(s_axis_tuser);
  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign a_in[i] = s_axis_tdata[WORD_W*i +: WORD_W];
    assign b_in[i] = s_axis_tdata[WORD_W*(i+3) +: WORD_W];
  end
  assign s_in = s_axis_tdata[WORD_W*6 +: WORD_W];

  // The pipeline moves whenever the skid buffer is free; no intake during reset.
  assign en            = !skid_v;
  assign s_axis_tready = en && !rst;

  // Component lanes.
  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3au_lane #(
      .FRAC_BITS (FRAC_BITS),
      .LANE      (i)
    ) u_lane (
      .clk  (clk),
      .en   (en),
      .op   (op_in),
      .a    (a_in),
      .b    (b_in),
      .s    (s_in),
      .prod (lane_prod[i]),
      .r    (lane_r[i]),
      .rovf (lane_rovf[i])
    );
  end

  // Dot product and sum of squares from the lane products.
  always_comb begin
    dsum  = 66'(lane_prod[0]) + 66'(lane_prod[1]) + 66'(lane_prod[2]);
    dsat  = sat66(dsum >>> FRAC_BITS);
    sqsum = $unsigned(lane_prod[0]) + $unsigned(lane_prod[1]) + $unsigned(lane_prod[2]);
  end

  // First two stages of carried operands.
  always_ff @(posedge clk) begin
    if (en) begin
      op1      <= op_in;
      a1       <= a_in;
      s1       <= s_in;
      op2      <= op1;
      a2       <= a1;
      s2       <= s1;
      dot2     <= (op1 == OP_DOT) ? dsat[WORD_W-1:0] : '0;
      dot_ovf2 <= (op1 == OP_DOT) && dsat[WORD_W];
      sq2      <= sqsum;
    end
  end

  // Collect the lane results next to the carried operands.
  always_comb begin
    p2         = '0;
    p2.op      = op2;
    p2.a       = a2;
    p2.s       = s2;
    p2.dot     = dot2;
    p2.dot_ovf = dot_ovf2;
    for (int i = 0; i < 3; i++) begin
      p2.r[i]    = lane_r[i];
      p2.rovf[i] = lane_rovf[i];
    end
  end

  v3au_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sq2),
    .root (root)
  );

  // Divider operands: magnitudes of a over |scalar| or over the root.
  always_comb begin
    pe      = pl[SQ_STAGES-1];
    pe.root = root;
    abs_s   = pe.s[WORD_W-1] ? WORD_W'(-pe.s) : pe.s;
    dden    = (pe.op == OP_DIV) ? abs_s : root;
    for (int i = 0; i < 3; i++) begin
      dnum[i]   = pe.a[i][WORD_W-1] ? WORD_W'(-pe.a[i]) : pe.a[i];
      pe.neg[i] = (pe.op == OP_DIV) ? (pe.a[i][WORD_W-1] ^ pe.s[WORD_W-1])
                                    : pe.a[i][WORD_W-1];
    end
    pe.dz = ((pe.op == OP_DIV) && (pe.s == '0)) ||
            ((pe.op == OP_NORM) && (root == '0));
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3au_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk (clk),
      .en  (en),
      .num (dnum[i]),
      .den (dden),
      .quo (quo[i])
    );
  end

  // Delay lines beside the root and divider stages.
  always_ff @(posedge clk) begin
    if (en) begin
      pl[0] <= p2;
      for (int n = 1; n < SQ_STAGES; n++) begin
        pl[n] <= pl[n-1];
      end
      dl[0] <= pe;
      for (int n = 1; n < QW; n++) begin
        dl[n] <= dl[n-1];
      end
    end
  end

  // Valid flags travel with the requests.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      for (int n = 0; n < SQ_STAGES; n++) begin
        pv[n] <= 1'b0;
      end
      for (int n = 0; n < QW; n++) begin
        dv[n] <= 1'b0;
      end
    end else if (en) begin
      v1    <= s_axis_tvalid;
      v2    <= v1;
      pv[0] <= v2;
      for (int n = 1; n < SQ_STAGES; n++) begin
        pv[n] <= pv[n-1];
      end
      dv[0] <= pv[SQ_STAGES-1];
      for (int n = 1; n < QW; n++) begin
        dv[n] <= dv[n-1];
      end
    end
  end

  // Merge the lanes into one result by operation.
  always_comb begin
    logic [QW-1:0] lim;
    res = '0;
    lim = '0;
    unique case (dl[QW-1].op)
      OP_ADD, OP_SUB, OP_SCALE, OP_CROSS: begin
        res.r   = dl[QW-1].r;
        res.ovf = |dl[QW-1].rovf;
      end
      OP_DOT: begin
        res.sc  = dl[QW-1].dot;
        res.ovf = dl[QW-1].dot_ovf;
      end
      OP_MAG: begin
        if (dl[QW-1].root[WORD_W-1]) begin
          res.sc  = 32'h7fff_ffff;
          res.ovf = 1'b1;
        end else begin
          res.sc = dl[QW-1].root;
        end
      end
      OP_DIV, OP_NORM: begin
        if (dl[QW-1].dz) begin
          res.dz = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            lim = dl[QW-1].neg[i] ? QW'(32'h8000_0000) : QW'(32'h7fff_ffff);
            if (quo[i] > lim) begin
              res.ovf  = 1'b1;
              res.r[i] = dl[QW-1].neg[i] ? 32'h8000_0000 : 32'h7fff_ffff;
            end else begin
              res.r[i] = dl[QW-1].neg[i] ? (~quo[i][WORD_W-1:0]) + 32'd1
                                         : quo[i][WORD_W-1:0];
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Output register with a one-entry skid buffer behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_v        <= 1'b0;
    end else begin
      if (!m_axis_tvalid || m_axis_tready) begin
        if (skid_v) begin
          m_axis_tvalid <= 1'b1;
          od            <= skid_d;
          skid_v        <= 1'b0;
        end else if (en && dv[QW-1]) begin
          m_axis_tvalid <= 1'b1;
          od            <= res;
        end else begin
          m_axis_tvalid <= 1'b0;
        end
      end else if (en && dv[QW-1]) begin
        skid_v <= 1'b1;
        skid_d <= res;
      end
    end
  end

  assign m_axis_tdata = {6'b0, od};

`ifndef SYNTHESIS
  // A parked result always has a result ahead of it on the output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> m_axis_tvalid)
    else $error("skid buffer holds a result while the output is empty");

  // The skid buffer drains in the cycle the output is taken.
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_v && m_axis_tready) |=> !skid_v)
    else $error("skid buffer did not drain after the output was taken");

  // Division by zero never reports a saturation as well.
  a_dz_no_ovf: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[128] && m_axis_tdata[129]))
    else $error("divide by zero and overflow raised together");

  // Division by zero yields all-zero data fields.
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[128]) |-> (m_axis_tdata[127:0] == '0))
    else $error("divide by zero result carries nonzero data");
`endif

endmodule

FILE: sv/v3au_lane.sv
// One vector component lane: multipliers, then add, subtract, scale or cross term.
module v3au_lane import v3au_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int LANE      = 0
) (
  input  logic                     clk,
  input  logic                     en,
  input  op_t                      op,
  input  logic [2:0][WORD_W-1:0]   a,
  input  logic [2:0][WORD_W-1:0]   b,
  input  logic [WORD_W-1:0]        s,
  output logic signed [63:0]       prod,
  output logic [WORD_W-1:0]        r,
  output logic                     rovf
);

  localparam int J = (LANE + 1) % 3;
  localparam int K = (LANE + 2) % 3;

  logic signed [WORD_W-1:0] x0;
  logic signed [WORD_W-1:0] y0;
  logic signed [63:0]       m0;
  logic signed [63:0]       m1;
  logic signed [WORD_W-1:0] ai;
  logic signed [WORD_W-1:0] bi;
  op_t                      opa;
  logic signed [65:0]       w;
  logic [WORD_W:0]          sat;

  // Pick the operands of the main multiplier for this operation.
  always_comb begin
    x0 = $signed(a[LANE]);
    y0 = $signed(a[LANE]);
    unique case (op)
      OP_SCALE: y0 = $signed(s);
      OP_DOT:   y0 = $signed(b[LANE]);
      OP_CROSS: begin
        x0 = $signed(a[J]);
        y0 = $signed(b[K]);
      end
      default: ;
    endcase
  end

  // First stage: products and the plain operands.
  always_ff @(posedge clk) begin
    if (en) begin
      m0  <= x0 * y0;
      m1  <= $signed(a[K]) * $signed(b[J]);
      ai  <= $signed(a[LANE]);
      bi  <= $signed(b[LANE]);
      opa <= op;
    end
  end

  assign prod = m0;

  // Exact lane value; the arithmetic shift floors the product sums.
  always_comb begin
    unique case (opa)
      OP_ADD:   w = 66'(ai) + 66'(bi);
      OP_SUB:   w = 66'(ai) - 66'(bi);
      OP_SCALE: w = 66'(m0) >>> FRAC_BITS;
      OP_CROSS: w = (66'(m0) - 66'(m1)) >>> FRAC_BITS;
      default:  w = '0;
    endcase
    sat = sat66(w);
  end

  // Second stage: saturated lane result.
  always_ff @(posedge clk) begin
    if (en) begin
      r    <= sat[WORD_W-1:0];
      rovf <= sat[WORD_W];
    end
  end

endmodule

FILE: sv/v3au_isqrt.sv
// Pipelined integer square root of a 64-bit value, one root bit per stage.
module v3au_isqrt import v3au_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [63:0]       rad,
  output logic [WORD_W-1:0] root
);

  logic [63:0]       rd [SQ_STAGES];
  logic [33:0]       rm [SQ_STAGES];
  logic [WORD_W-1:0] rt [SQ_STAGES];

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_st
    logic [63:0]       rd_in;
    logic [33:0]       rm_in;
    logic [WORD_W-1:0] rt_in;
    logic [35:0]       x;
    logic [35:0]       t;

    if (g == 0) begin : g_first
      assign rd_in = rad;
      assign rm_in = '0;
      assign rt_in = '0;
    end else begin : g_next
      assign rd_in = rd[g-1];
      assign rm_in = rm[g-1];
      assign rt_in = rt[g-1];
    end

    // Bring down two radicand bits and try the next root bit.
    assign x = {rm_in, rd_in[63:62]};
    assign t = {2'b00, rt_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        rd[g] <= rd_in << 2;
        if (x >= t) begin
          rm[g] <= 34'(x - t);
          rt[g] <= {rt_in[WORD_W-2:0], 1'b1};
        end else begin
          rm[g] <= x[33:0];
          rt[g] <= {rt_in[WORD_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = rt[SQ_STAGES-1];

endmodule

FILE: sv/v3au_div.sv
// Pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit per stage.
module v3au_div import v3au_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int QW = WORD_W + FRAC_BITS
) (
  input  logic              clk,
  input  logic              en,
  input  logic [WORD_W-1:0] num,
  input  logic [WORD_W-1:0] den,
  output logic [QW-1:0]     quo
);

  logic [QW-1:0]     nq [QW];
  logic [WORD_W-1:0] rm [QW];
  logic [WORD_W-1:0] dn [QW];

  for (genvar g = 0; g < QW; g++) begin : g_st
    logic [QW-1:0]     nq_in;
    logic [WORD_W-1:0] rm_in;
    logic [WORD_W-1:0] dn_in;
    logic [WORD_W:0]   x;
    logic              ge;

    if (g == 0) begin : g_first
      assign nq_in = {num, {FRAC_BITS{1'b0}}};
      assign rm_in = '0;
      assign dn_in = den;
    end else begin : g_next
      assign nq_in = nq[g-1];
      assign rm_in = rm[g-1];
      assign dn_in = dn[g-1];
    end

    // Shift in the next dividend bit and subtract where the divisor fits.
    assign x  = {rm_in, nq_in[QW-1]};
    assign ge = (x >= {1'b0, dn_in});

    always_ff @(posedge clk) begin
      if (en) begin
        nq[g] <= {nq_in[QW-2:0], ge};
        rm[g] <= ge ? WORD_W'(x - {1'b0, dn_in}) : x[WORD_W-1:0];
        dn[g] <= dn_in;
      end
    end
  end

  assign quo = nq[QW-1];

endmodule

FILE: test/tb_vector3_arithmetic_unit.sv
// Testbench for the 3D vector arithmetic unit: random and directed requests against a predictor.
`timescale 1ns / 100ps

module tb_vector3_arithmetic_unit import v3au_pkg::*;;

  localparam int FRAC = 16;
  localparam int LATENCY = 66 + FRAC;
  localparam longint CYCLE_LIMIT = 400000;

  // Expected result of one request.
  typedef struct packed {
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rz;
    logic [31:0] sc;
    logic        dz;
    logic        ovf;
  } vres_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [223:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [135:0] m_axis_tdata;

  vres_t  expected_q[$];
  int     mismatches;
  longint cycles;
  bit     sink_stall_on;
  int     sink_wait;

  vector3_arithmetic_unit #(.FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Clamp a wide value to one word, noting saturation.
  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic ovf);
    if (v > 128'sd2147483647) begin
      ovf = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -128'sd2147483648) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Floor of sqrt of an unsigned value, bit by bit.
  function automatic logic [63:0] root_floor(input logic [127:0] n);
    logic [127:0] res, bitv;
    res = 0;
    bitv = 128'd1 << 126;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[63:0];
  endfunction

  // Fixed-point quotient truncated toward zero.
  function automatic logic signed [127:0] fx_quot(input logic signed [127:0] num,
                                                  input logic signed [127:0] den);
    logic [127:0] un, ud, q;
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    q = (un << FRAC) / ud;
    return ((num < 0) != (den < 0)) ? -$signed(q) : $signed(q);
  endfunction

  // Work out the result of one vector operation.
  function automatic vres_t vector_result(input op_t op, input logic [223:0] d);
    logic signed [127:0] a[3], b[3], s, acc, r[3];
    logic [127:0] sq;
    logic [63:0] mag;
    vres_t e;
    logic ovf;
    int j, k;
    for (int i = 0; i < 3; i++) begin
      a[i] = $signed(d[32*i +: 32]);
      b[i] = $signed(d[32*(i+3) +: 32]);
      r[i] = 0;
    end
    s = $signed(d[192 +: 32]);
    e = '0;
    ovf = 1'b0;
    case (op)
      OP_ADD: for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
      OP_SUB: for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
      OP_SCALE: for (int i = 0; i < 3; i++) r[i] = (a[i] * s) >>> FRAC;
      OP_DIV: begin
        if (s == 0) e.dz = 1'b1;
        else for (int i = 0; i < 3; i++) r[i] = fx_quot(a[i], s);
      end
      OP_DOT: begin
        acc = (a[0]*b[0] + a[1]*b[1] + a[2]*b[2]) >>> FRAC;
        e.sc = clamp32(acc, ovf);
      end
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          j = (i + 1) % 3;
          k = (i + 2) % 3;
          r[i] = (a[j]*b[k] - a[k]*b[j]) >>> FRAC;
        end
      end
      default: begin
        sq = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
        mag = root_floor(sq);
        if (op == OP_MAG) e.sc = clamp32($signed({64'd0, mag}), ovf);
        else if (mag == 0) e.dz = 1'b1;
        else for (int i = 0; i < 3; i++) r[i] = fx_quot(a[i], $signed({64'd0, mag}));
      end
    endcase
    if (op != OP_DOT && op != OP_MAG) begin
      e.rx = clamp32(r[0], ovf);
      e.ry = clamp32(r[1], ovf);
      e.rz = clamp32(r[2], ovf);
    end
    e.ovf = ovf;
    return e;
  endfunction

  // Send one request after a random gap (none when gaps is off) and record its expected result.
  // The valid line stays high after acceptance until the next gap or a drain drops it.
  task automatic send_request(input op_t op, input logic [223:0] d, input bit gaps = 1'b1);
    int gap;
    gap = gaps ? $urandom_range(0, 7) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    expected_q.push_back(vector_result(op, d));
  endtask

  // Random word biased toward extremes and small values.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'd0;
      3: return $urandom_range(0, 8) << 16;
      4: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [223:0] pick_data();
    logic [223:0] d;
    for (int i = 0; i < 7; i++) d[32*i +: 32] = pick_word();
    return d;
  endfunction

  // Stop sending and wait until every expected result has come.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Directed: extremes, every operation, zero divisor and zero vector.
  task automatic test_directed();
    logic [223:0] d;
    for (int o = 0; o < 8; o++) begin
      send_request(op_t'(o), {7{32'h7fff_ffff}});
      send_request(op_t'(o), {7{32'h8000_0000}});
      d = {32'h0002_0000, 32'h0001_0000, 32'hffff_0000, 32'h0003_0000,
           32'h0000_8000, 32'hfffe_0000, 32'h0004_0000};
      send_request(op_t'(o), d);
    end
    send_request(OP_DIV, {32'd0, {6{32'h0001_0000}}});
    send_request(OP_NORM, {{4{32'h1234_5678}}, 96'd0});
  endtask

  // Random operations with all field values.
  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) begin
      send_request(op_t'($urandom_range(0, 7)), pick_data());
      if (n == count / 2) wait_drained();
    end
  endtask

  // Back-to-back requests with the sink stalling.
  task automatic test_burst(input int count);
    for (int n = 0; n < count; n++) send_request(op_t'($urandom_range(0, 7)), pick_data(), 1'b0);
  endtask

  // Result checker and sink stall; once stalls are on, the sink draws a wait for every result.
  always @(posedge clk) begin
    vres_t got, want;
    logic  rdy;
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_wait = 0;
    end else begin
      rdy = 1'b1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
               m_axis_tdata[127:96], m_axis_tdata[128], m_axis_tdata[129]};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h actual %h", want, got);
          end
        end
        if (sink_stall_on) sink_wait = $urandom_range(0, 7);
      end
      if (sink_wait > 0) begin
        rdy = 1'b0;
        sink_wait--;
      end
      m_axis_tready <= rdy;
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_vector3_arithmetic_unit: errors");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    mismatches = 0;
    cycles = 0;
    sink_stall_on = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    sink_stall_on = 1'b1;
    test_random(1600);
    test_burst(300);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb_vector3_arithmetic_unit: clean");
    end else begin
      $display("tb_vector3_arithmetic_unit: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/v3au_pkg.sv
sv/v3au_lane.sv
sv/v3au_isqrt.sv
sv/v3au_div.sv
sv/vector3_arithmetic_unit.sv
test/tb_vector3_arithmetic_unit.sv
